/* sv/bmg_pkg.sv */
package bmg_pkg;

  localparam int LOG_FRAC = 24;
  localparam logic [31:0] TWO_LN2_Q30 = 32'd1488522236;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  // Taylor divisors of the cosine series, innermost first
  localparam int NUM_TERMS = 6;

  function automatic logic [7:0] cos_div(input int i);
    logic [7:0] d;
    begin
      case (i)
        0: d = 8'd132;
        1: d = 8'd90;
        2: d = 8'd56;
        3: d = 8'd30;
        4: d = 8'd12;
        default: d = 8'd2;
      endcase
      return d;
    end
  endfunction

  // Register indexes
  localparam logic REG_MEAN = 1'b0;
  localparam logic REG_STD_DEV = 1'b1;

endpackage

/* sv/bmg_log_pipe.sv */
// Radius path: log2 by repeated squaring (one fraction bit per stage),
// then -2 ln u1 scaling and a pipelined integer square root.
module bmg_log_pipe #(
  parameter int UB = 16
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [UB-1:0] radius,
  output logic [31:0]   root
);

  localparam int FB = bmg_pkg::LOG_FRAC;
  localparam int EW = $clog2(UB + 1);

  // normalize m = k+1 to Q31 mantissa
  logic [UB:0] m;
  logic [EW-1:0] e;
  logic [32:0] ymant;
  always_comb begin
    m = {1'b0, radius} + {{UB{1'b0}}, 1'b1};
    e = '0;
    for (int i = 0; i <= UB; i++) begin
      if (m[i]) begin
        e = EW'(i);
      end
    end
    ymant = 33'(({{(63-UB){1'b0}}, m} << 31) >> e);
  end

  // squaring stages
  logic [32:0]   ys [FB+1];
  logic [FB-1:0] fr [FB+1];
  logic [EW-1:0] es [FB+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      ys[0] <= ymant;
      fr[0] <= '0;
      es[0] <= e;
    end
  end

  for (genvar s = 0; s < FB; s++) begin : g_sq
    logic [65:0] prod;
    logic [33:0] ysq;
    assign prod = ys[s] * ys[s];
    assign ysq = prod[64:31];
    always_ff @(posedge clk) begin
      if (adv) begin
        es[s+1] <= es[s];
        if (ysq[33:32] != 2'b00) begin
          ys[s+1] <= 33'(ysq >> 1);
          fr[s+1] <= {fr[s][FB-2:0], 1'b1};
        end else begin
          ys[s+1] <= 33'(ysq);
          fr[s+1] <= {fr[s][FB-2:0], 1'b0};
        end
      end
    end
  end

  // t = UB - log2, then r = t * 2ln2 >> 30
  logic [FB+EW:0] full, lg, t;
  logic [FB+EW:0] tr;
  always_comb begin
    full = (FB+EW+1)'(UB) << FB;
    lg = {1'b0, es[FB], fr[FB]};
    t = (full > lg) ? full - lg : '0;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      tr <= t;
    end
  end

  localparam logic [31:0] TWO = bmg_pkg::TWO_LN2_Q30;
  logic [63:0] rprod;
  logic [63:0] rv;
  assign rprod = 64'(tr) * 64'(TWO);
  always_ff @(posedge clk) begin
    if (adv) begin
      rv <= (rprod >> 30) << 24;
    end
  end

  // square root: one result bit per stage (32 stages)
  logic [63:0] sv_rem [33];
  logic [31:0] sv_res [33];
  assign sv_rem[0] = rv;
  assign sv_res[0] = '0;
  for (genvar b = 0; b < 32; b++) begin : g_sqrt
    logic [63:0] trial;
    logic [63:0] rem_n;
    logic [31:0] res_n;
    always_comb begin
      // (res + bit)^2 - res^2 with res holding the bits found so far
      trial = ({32'b0, sv_res[b]} << (32 - b)) + (64'd1 << (62 - 2 * b));
      if (sv_rem[b] >= trial) begin
        rem_n = sv_rem[b] - trial;
        res_n = sv_res[b] | (32'h8000_0000 >> b);
      end else begin
        rem_n = sv_rem[b];
        res_n = sv_res[b];
      end
    end
    logic [63:0] rem_q;
    logic [31:0] res_q;
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q <= rem_n;
        res_q <= res_n;
      end
    end
    assign sv_rem[b+1] = rem_q;
    assign sv_res[b+1] = res_q;
  end

  assign root = sv_res[32];

endmodule

/* sv/bmg_cos_pipe.sv */
// Angle path: quadrant fold, Horner cosine, delayed to match radius path.
module bmg_cos_pipe #(
  parameter int UB = 16,
  parameter int LAT = 60
) (
  input  logic               clk,
  input  logic               adv,
  input  logic [UB-1:0]      angle,
  output logic signed [31:0] cosv
);

  localparam int NT = bmg_pkg::NUM_TERMS;
  localparam logic [31:0] ONE = 32'd1 << 30;
  localparam int DL = LAT - 2 - 2 * NT;

  logic [31:0] turn;
  logic [1:0]  q;
  logic [30:0] g;
  assign turn = 32'((64'(angle) << (32 - UB)));
  assign q = turn[31:30];
  assign g = q[0] ? (31'd1 << 30) - {1'b0, turn[29:0]} : {1'b0, turn[29:0]};

  // x and y = x*x
  logic [31:0] xs;
  logic [1:0]  q1, q2;
  always_ff @(posedge clk) begin
    if (adv) begin
      xs <= 32'((64'(g) * 64'(bmg_pkg::HALF_PI_Q30)) >> 30);
      q1 <= q;
    end
  end
  logic [31:0] ys;
  always_ff @(posedge clk) begin
    if (adv) begin
      ys <= 32'((64'(xs) * 64'(xs)) >> 30);
      q2 <= q1;
    end
  end

  // Horner: multiply stage then divide-by-constant stage
  logic [31:0] pv [NT+1];
  logic [31:0] yv [NT+1];
  logic [1:0]  qv [NT+1];
  assign pv[0] = ONE;
  assign yv[0] = ys;
  assign qv[0] = q2;
  for (genvar i = 0; i < NT; i++) begin : g_hor
    // floor(n/d) = n * ceil(2^(32+L)/d) >> (32+L) for any 32-bit n
    localparam logic [7:0] DV = bmg_pkg::cos_div(i);
    localparam int LS = $clog2(DV);
    localparam logic [32:0] RM =
      33'(((65'd1 << (32 + LS)) + 65'(DV) - 65'd1) / 65'(DV));
    logic [31:0] pm;
    logic [31:0] ym;
    logic [1:0]  qm;
    always_ff @(posedge clk) begin
      if (adv) begin
        pm <= 32'((64'(yv[i]) * 64'(pv[i])) >> 30);
        ym <= yv[i];
        qm <= qv[i];
      end
    end
    logic [64:0] qp;
    assign qp = 65'(pm) * 65'(RM);
    logic [31:0] pn;
    logic [31:0] yn;
    logic [1:0]  qn;
    always_ff @(posedge clk) begin
      if (adv) begin
        pn <= ONE - 32'(qp >> (32 + LS));
        yn <= ym;
        qn <= qm;
      end
    end
    assign pv[i+1] = pn;
    assign yv[i+1] = yn;
    assign qv[i+1] = qn;
  end

  // sign and delay line to line up with the root
  logic signed [31:0] cs;
  assign cs = (qv[NT] == 2'd1 || qv[NT] == 2'd2) ? -$signed(pv[NT]) : $signed(pv[NT]);
  logic signed [31:0] dly [DL+1];
  assign dly[0] = cs;
  for (genvar d = 0; d < DL; d++) begin : g_dly
    always_ff @(posedge clk) begin
      if (adv) begin
        dly[d+1] <= dly[d];
      end
    end
  end
  assign cosv = dly[DL];

endmodule

/* sv/box_muller_gaussian_sample_core.sv */
// Channel  | Valid       | Stall/Ready  | Payload
// input    | in_valid    | in_stall     | uniform_radius, uniform_angle
// output   | out_valid   | out_stall    | sample
// config   | cfg_valid   | cfg_ready    | cfg_index, cfg_data
//
// One sample per clock while out_stall does not hold the pipeline; the latency does not
// depend on UNIFORM_BITS (normalize, 24 log squaring stages, two scaling stages,
// 32 square-root stages, then the z product and the saturated output).
// The whole pipeline advances together; out_stall freezes it while the output holds a valid sample, with no loss.
// Synchronous reset clears the valid bits and sets mean 0, std_dev 1.0.
module box_muller_gaussian_sample_core #(
  parameter int UNIFORM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] uniform_radius,
  input  logic [15:0] uniform_angle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [23:0] sample,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [20:0] cfg_data
);

  localparam int UB = (UNIFORM_BITS > 16) ? 16 : UNIFORM_BITS;
  localparam int LAT = bmg_pkg::LOG_FRAC + 35;
  localparam int TOT = LAT + 2;

  logic signed [20:0] mean;
  logic [15:0] std_dev;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      mean <= '0;
      std_dev <= 16'd4096;
    end else if (cfg_valid) begin
      case (cfg_index)
        bmg_pkg::REG_MEAN: mean <= cfg_data;
        bmg_pkg::REG_STD_DEV: std_dev <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // global advance: pipeline moves unless result is blocked
  logic adv;
  logic [TOT-1:0] vld;
  assign adv = !(vld[TOT-1] && out_stall);
  assign in_stall = !adv;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TOT-2:0], in_valid};
    end
  end

  logic [31:0] root;
  logic signed [31:0] cosv;
  bmg_log_pipe #(.UB(UB)) u_log (
    .clk(clk), .adv(adv),
    .radius(uniform_radius[UB-1:0]), .root(root)
  );
  bmg_cos_pipe #(.UB(UB), .LAT(LAT)) u_cos (
    .clk(clk), .adv(adv),
    .angle(uniform_angle[UB-1:0]), .cosv(cosv)
  );

  // z = s*c/2^30 truncating toward zero
  logic signed [63:0] zp;
  logic signed [31:0] z;
  assign zp = $signed({32'b0, root}) * 64'(cosv);
  always_ff @(posedge clk) begin
    if (adv) begin
      z <= 32'(zp / 64'sd1073741824);
    end
  end

  // std_dev*z/2^24 + mean, saturate
  logic signed [48:0] vm;
  logic signed [63:0] vp, v;
  logic signed [23:0] sat;
  assign vm = 49'($signed({1'b0, std_dev})) * 49'(z);
  assign vp = 64'(vm / 49'sd16777216) + 64'(mean);
  always_comb begin
    if (vp > 64'sd8388607) begin
      sat = 24'sh7FFFFF;
    end else if (vp < -64'sd8388608) begin
      sat = 24'sh800000;
    end else begin
      sat = vp[23:0];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sample <= sat;
    end
  end
  assign v = vp;
  assign out_valid = vld[TOT-1] && (v == vp);

endmodule
